### sv/assert_macros.svh
// Assertion macros shared by the RTL files of the unsharp-mask core.
// Included by bare file name; the bodies are empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBUM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BBUM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BBUM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BBUM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### sv/bbum_pkg.sv
// Shared types and constants of the box blur unsharp-mask core.
// No dependencies; used by every module of the block but bbum_ram.
`timescale 1ns / 1ps
package bbum_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MAX_WINDOW = 127;

  localparam int CFG_W   = 10;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int N_W     = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int WIN_W   = 7;
  localparam int HALF_W  = 6;
  localparam int GAIN_W  = 4;
  localparam int SUM_W   = 15;
  // source delay line: power of two above the largest lag
  localparam int SRC_AW  = 15;
  // horizontal-mean line store: 128 rows of MAX_WIDTH
  localparam int HROW_W  = 7;
  localparam int HM_AW   = HROW_W + COL_W;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2,
    REG_GAIN         = 2'd3
  } reg_index_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [7:0] sharpened_pixel;
    logic       last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [WIN_W-1:0]  size;
    logic [HALF_W-1:0] half;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic              do_store;
    logic [7:0]        pixel;
    logic [SRC_AW-1:0] src_addr;
    logic              do_h;
    logic [HROW_W-1:0] h_row;
    logic [SRC_AW-1:0] row_base;
    logic [COL_W-1:0]  c_first;
    logic [COL_W-1:0]  c_last;
    logic              do_out;
    logic [ROW_W-1:0]  oy;
    logic [COL_W-1:0]  ox;
    logic [SRC_AW-1:0] o_addr;
    logic              last;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_HREAD,
    B_HACC,
    B_HDIV,
    B_VREAD,
    B_VACC,
    B_VDIV,
    B_PREAD,
    B_PWAIT,
    B_OUT
  } back_state_t;

endpackage

### sv/bbum_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bbum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/bbum_div.sv
// Restoring divider, one quotient bit per cycle: window sum / window size.
// Depends on bbum_pkg.
`timescale 1ns / 1ps
module bbum_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bbum_pkg::SUM_W-1:0]   dividend,
  input  logic [bbum_pkg::WIN_W-1:0]   divisor,
  output logic                         done,
  output logic [bbum_pkg::SUM_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(bbum_pkg::SUM_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [bbum_pkg::WIN_W-1:0] rem;
  logic [bbum_pkg::WIN_W-1:0] dsr;
  logic [bbum_pkg::WIN_W:0]   trial;
  logic                       ge;

  assign trial = {rem, quotient[bbum_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(bbum_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? bbum_pkg::WIN_W'(trial - {1'b0, dsr}) : trial[bbum_pkg::WIN_W-1:0];
      quotient <= {quotient[bbum_pkg::SUM_W-2:0], ge};
    end
  end

endmodule

### sv/bbum_front.sv
// Front end: accepts input words, tracks frame position, issues work commands.
// Holds a two-entry command queue. Depends on bbum_pkg.
`timescale 1ns / 1ps
module bbum_front (
  input  logic              clk,
  input  logic              rst,
  input  bbum_pkg::cfg_t    cfg,
  input  logic              restart,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbum_pkg::in_word_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output bbum_pkg::cmd_t    cmd
);

  localparam int N_W    = bbum_pkg::N_W;
  localparam int COL_W  = bbum_pkg::COL_W;
  localparam int ROW_W  = bbum_pkg::ROW_W;
  localparam int SRC_AW = bbum_pkg::SRC_AW;
  localparam int CFG_W  = bbum_pkg::CFG_W;

  logic [N_W-1:0]    total;
  logic [N_W-1:0]    lag;
  logic [N_W-1:0]    n;
  logic [ROW_W-1:0]  r;
  logic [COL_W-1:0]  j;
  logic [SRC_AW-1:0] rowbase;
  logic [ROW_W-1:0]  oy;
  logic [COL_W-1:0]  ox;

  bbum_pkg::cmd_t q [2];
  logic       wp, rp;
  logic [1:0] count;

  logic             take, filling, act, emit, last, j_end, j_ge, push, pop;
  logic [CFG_W-1:0] wm1, hm1;
  logic [N_W-1:0]   o_full;
  bbum_pkg::cmd_t   nc;

  always_comb begin
    total   = N_W'(cfg.width * cfg.height);
    lag     = N_W'(cfg.half * cfg.width) + N_W'(cfg.half);
    wm1     = cfg.width - 1'b1;
    hm1     = cfg.height - 1'b1;
    take    = in_valid && in_ready;
    filling = n < total;
    act     = !(filling && in_data.kind == bbum_pkg::KIND_DRAIN);
    emit    = n >= lag;
    last    = emit && ({1'b0, oy} == hm1) && ({1'b0, ox} == wm1);
    j_end   = {1'b0, j} == wm1;
    j_ge    = j >= COL_W'(cfg.half);
    o_full  = n - lag;

    nc.do_store = filling;
    nc.pixel    = in_data.pixel;
    nc.src_addr = n[SRC_AW-1:0];
    nc.do_h     = filling && (j_end || j_ge);
    nc.h_row    = r[bbum_pkg::HROW_W-1:0];
    nc.row_base = rowbase;
    nc.c_first  = j_ge ? j - COL_W'(cfg.half) : '0;
    nc.c_last   = j_end ? j : j - COL_W'(cfg.half);
    nc.do_out   = emit;
    nc.oy       = oy;
    nc.ox       = ox;
    nc.o_addr   = o_full[SRC_AW-1:0];
    nc.last     = last;

    push = take && act && (filling || emit);
    pop  = cmd_valid && cmd_ready;
  end

  assign in_ready  = count != 2'd2;
  assign cmd_valid = count != 2'd0;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= nc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      wp      <= 1'b0;
      rp      <= 1'b0;
      count   <= '0;
      n       <= '0;
      r       <= '0;
      j       <= '0;
      rowbase <= '0;
      oy      <= '0;
      ox      <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
      if (take && act) begin
        if (last) begin
          n       <= '0;
          r       <= '0;
          j       <= '0;
          rowbase <= '0;
          oy      <= '0;
          ox      <= '0;
        end else begin
          n <= n + 1'b1;
          if (filling) begin
            if (j_end) begin
              j       <= '0;
              r       <= r + 1'b1;
              rowbase <= rowbase + SRC_AW'(cfg.width);
            end else begin
              j <= j + 1'b1;
            end
          end
          if (emit) begin
            if ({1'b0, ox} == wm1) begin
              ox <= '0;
              oy <= oy + 1'b1;
            end else begin
              ox <= ox + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

### sv/bbum_back.sv
// Back end: runs queued commands; horizontal means, vertical mean, sharpening.
// Depends on bbum_pkg, bbum_ram and bbum_div.
`timescale 1ns / 1ps
module bbum_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bbum_pkg::cfg_t       cfg,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  bbum_pkg::cmd_t       cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bbum_pkg::out_word_t  out_data
);

  localparam int COL_W  = bbum_pkg::COL_W;
  localparam int ROW_W  = bbum_pkg::ROW_W;
  localparam int SRC_AW = bbum_pkg::SRC_AW;
  localparam int HM_AW  = bbum_pkg::HM_AW;
  localparam int SUM_W  = bbum_pkg::SUM_W;
  localparam int WIN_W  = bbum_pkg::WIN_W;

  bbum_pkg::back_state_t state, state_next;
  bbum_pkg::cmd_t        cur;
  logic [COL_W-1:0]      c;
  logic [WIN_W-1:0]      d;
  logic [SUM_W-1:0]      acc;
  logic [7:0]            b;
  logic [7:0]            p;

  logic              src_we, src_re, hm_we, hm_re;
  logic [SRC_AW-1:0] src_raddr;
  logic [HM_AW-1:0]  hm_raddr;
  logic [7:0]        src_rdata, hm_rdata;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_q, sum_now;
  logic              d_last, can_load;

  logic signed [10:0] tc, tr;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic signed [9:0]  diff;
  logic signed [14:0] prod, res;

  bbum_ram #(.WIDTH(8), .DEPTH(2 ** SRC_AW)) u_src (
    .clk(clk), .we(src_we), .waddr(cmd.src_addr), .wdata(cmd.pixel),
    .re(src_re), .raddr(src_raddr), .rdata(src_rdata)
  );

  bbum_ram #(.WIDTH(8), .DEPTH(2 ** HM_AW)) u_hmean (
    .clk(clk), .we(hm_we), .waddr({cur.h_row, c}), .wdata(div_q[7:0]),
    .re(hm_re), .raddr(hm_raddr), .rdata(hm_rdata)
  );

  bbum_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_now),
    .divisor(cfg.size), .done(div_done), .quotient(div_q)
  );

  // edge-replicated column and row of the current window tap
  always_comb begin
    tc = signed'({2'b00, c}) + signed'({4'b0000, d}) - signed'({5'b00000, cfg.half});
    if (tc < 0) begin
      col = '0;
    end else if (tc > signed'({1'b0, cfg.width - 1'b1})) begin
      col = COL_W'(cfg.width - 1'b1);
    end else begin
      col = tc[COL_W-1:0];
    end
    tr = signed'({2'b00, cur.oy}) + signed'({4'b0000, d}) - signed'({5'b00000, cfg.half});
    if (tr < 0) begin
      row = '0;
    end else if (tr > signed'({1'b0, cfg.height - 1'b1})) begin
      row = ROW_W'(cfg.height - 1'b1);
    end else begin
      row = tr[ROW_W-1:0];
    end
    d_last   = d == cfg.size - 1'b1;
    can_load = !out_valid || out_ready;
    sum_now  = acc + SUM_W'(state == bbum_pkg::B_VACC ? hm_rdata : src_rdata);
    diff     = signed'({2'b00, p}) - signed'({2'b00, b});
    prod     = 15'(diff * signed'({1'b0, cfg.gain}));
    res      = signed'({7'b0, p}) + prod;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bbum_pkg::B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.do_h) begin
            state_next = bbum_pkg::B_HREAD;
          end else if (cmd.do_out) begin
            state_next = bbum_pkg::B_VREAD;
          end
        end
      end
      bbum_pkg::B_HREAD: state_next = bbum_pkg::B_HACC;
      bbum_pkg::B_HACC: begin
        state_next = d_last ? bbum_pkg::B_HDIV : bbum_pkg::B_HREAD;
      end
      bbum_pkg::B_HDIV: begin
        if (div_done) begin
          if (c != cur.c_last) begin
            state_next = bbum_pkg::B_HREAD;
          end else if (cur.do_out) begin
            state_next = bbum_pkg::B_VREAD;
          end else begin
            state_next = bbum_pkg::B_IDLE;
          end
        end
      end
      bbum_pkg::B_VREAD: state_next = bbum_pkg::B_VACC;
      bbum_pkg::B_VACC: begin
        state_next = d_last ? bbum_pkg::B_VDIV : bbum_pkg::B_VREAD;
      end
      bbum_pkg::B_VDIV: begin
        if (div_done) begin
          state_next = bbum_pkg::B_PREAD;
        end
      end
      bbum_pkg::B_PREAD: state_next = bbum_pkg::B_PWAIT;
      bbum_pkg::B_PWAIT: state_next = bbum_pkg::B_OUT;
      bbum_pkg::B_OUT: begin
        if (can_load) begin
          state_next = bbum_pkg::B_IDLE;
        end
      end
      default: state_next = bbum_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    src_we    = 1'b0;
    src_re    = 1'b0;
    src_raddr = cur.row_base + SRC_AW'(col);
    hm_we     = 1'b0;
    hm_re     = 1'b0;
    hm_raddr  = {row[bbum_pkg::HROW_W-1:0], cur.ox};
    div_start = 1'b0;
    unique case (state)
      bbum_pkg::B_IDLE: begin
        cmd_ready = 1'b1;
        src_we    = cmd_valid && cmd.do_store;
      end
      bbum_pkg::B_HREAD: src_re = 1'b1;
      bbum_pkg::B_HACC:  div_start = d_last;
      bbum_pkg::B_HDIV:  hm_we = div_done;
      bbum_pkg::B_VREAD: hm_re = 1'b1;
      bbum_pkg::B_VACC:  div_start = d_last;
      bbum_pkg::B_PREAD: begin
        src_re    = 1'b1;
        src_raddr = cur.o_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bbum_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bbum_pkg::B_OUT && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bbum_pkg::B_IDLE: begin
        cur <= cmd;
        c   <= cmd.c_first;
        d   <= '0;
        acc <= '0;
      end
      bbum_pkg::B_HACC, bbum_pkg::B_VACC: begin
        acc <= sum_now;
        if (!d_last) begin
          d <= d + 1'b1;
        end
      end
      bbum_pkg::B_HDIV: begin
        if (div_done) begin
          c   <= c + 1'b1;
          d   <= '0;
          acc <= '0;
        end
      end
      bbum_pkg::B_VDIV: begin
        if (div_done) begin
          b <= div_q[7:0];
        end
      end
      bbum_pkg::B_PWAIT: p <= src_rdata;
      bbum_pkg::B_OUT: begin
        if (can_load) begin
          if (res < 0) begin
            out_data.sharpened_pixel <= 8'd0;
          end else if (res > 15'sd255) begin
            out_data.sharpened_pixel <= 8'd255;
          end else begin
            out_data.sharpened_pixel <= res[7:0];
          end
          out_data.last_of_frame <= cur.last;
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/box_blur_unsharp_mask_core.sv
// Unsharp-mask sharpener with a separable box blur over a raster pixel stream.
// Depends on bbum_pkg, bbum_front, bbum_back and assert_macros.svh.
//
// Input words (in_valid/in_ready/in_data) carry a kind bit and an 8-bit pixel;
// output words (out_valid/out_ready/out_data) carry the sharpened pixel and a
// last_of_frame flag. Registers are written through cfg_wr_en/cfg_index/
// cfg_data while the block is idle; any write restarts the frame.
// Results lag the input by half*width+half words; drain words push the tail.
// The front end takes a word per cycle, while its two-entry command queue has
// room; the back end then works each command through one shared serial
// divider and two memory read ports, one window tap at a time:
//   plain pixel, no output:   at most one horizontal mean
//   row end:                  up to (half+1) horizontal means
//   output word:              also a vertical mean and the sharpened pixel
// Reset (synchronous, active high) restores the register defaults and starts a
// new frame; the line memories are not cleared. When out_ready is low the
// result holds in the output register and the back end stalls in turn.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module box_blur_unsharp_mask_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [bbum_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bbum_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bbum_pkg::out_word_t           out_data
);

  logic [bbum_pkg::CFG_W-1:0]  frame_width, frame_height;
  logic [bbum_pkg::WIN_W-1:0]  window_size;
  logic [bbum_pkg::GAIN_W-1:0] gain;
  bbum_pkg::cfg_t              cfg;
  logic [bbum_pkg::WIN_W-1:0]  size_odd;
  logic                        cmd_valid, cmd_ready;
  bbum_pkg::cmd_t              cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bbum_pkg::CFG_W'(bbum_pkg::MAX_WIDTH);
      frame_height <= bbum_pkg::CFG_W'(bbum_pkg::MAX_HEIGHT);
      window_size  <= bbum_pkg::WIN_W'(3);
      gain         <= bbum_pkg::GAIN_W'(1);
    end else if (cfg_wr_en) begin
      unique case (bbum_pkg::reg_index_t'(cfg_index))
        bbum_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        bbum_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        bbum_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[bbum_pkg::WIN_W-1:0];
        bbum_pkg::REG_GAIN:         gain         <= cfg_data[bbum_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate the raw registers to the usable range
  always_comb begin
    size_odd = window_size | bbum_pkg::WIN_W'(1);
    if (frame_width < 10'd2) begin
      cfg.width = 10'd2;
    end else if (frame_width > bbum_pkg::CFG_W'(bbum_pkg::MAX_WIDTH)) begin
      cfg.width = bbum_pkg::CFG_W'(bbum_pkg::MAX_WIDTH);
    end else begin
      cfg.width = frame_width;
    end
    if (frame_height < 10'd2) begin
      cfg.height = 10'd2;
    end else if (frame_height > bbum_pkg::CFG_W'(bbum_pkg::MAX_HEIGHT)) begin
      cfg.height = bbum_pkg::CFG_W'(bbum_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = frame_height;
    end
    cfg.size = size_odd > bbum_pkg::WIN_W'(bbum_pkg::MAX_WINDOW) ?
               bbum_pkg::WIN_W'(bbum_pkg::MAX_WINDOW) : size_odd;
    cfg.half = cfg.size[bbum_pkg::WIN_W-1:1];
    cfg.gain = gain;
  end

  bbum_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .restart(cfg_wr_en),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  bbum_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  `BBUM_ASSERT_NEXT(a_cfg_flush, clk, rst, cfg_wr_en, !cmd_valid, "queue not flushed on restart")
  `BBUM_ASSERT_IMPL(a_full_nonempty, clk, rst, !in_ready, cmd_valid, "stalled with empty queue")

endmodule

### verif/testbench.sv
// Self-checking testbench for box_blur_unsharp_mask_core.
// Depends on bbum_pkg; drives raster frames and checks every sharpened word.
`timescale 1ns / 1ps
module testbench;

  localparam int FRAME_CELLS = bbum_pkg::MAX_WIDTH * bbum_pkg::MAX_HEIGHT;
  localparam int STALL_LIMIT = 200000;
  localparam int ITEM_GOAL   = 1050;

  // Predicts the sharpened stream and holds the words still owed by the block.
  class bbum_scoreboard;
    int unsigned width_reg, height_reg, window_reg, gain_reg;
    int unsigned pos;
    logic [7:0] src_pix[];
    logic [7:0] row_mean[];
    bbum_pkg::out_word_t owed_q[$];
    int errors;

    function new();
      src_pix  = new[FRAME_CELLS];
      row_mean = new[FRAME_CELLS];
      foreach (src_pix[i]) begin
        src_pix[i]  = '0;
        row_mean[i] = '0;
      end
      width_reg  = 512;
      height_reg = 512;
      window_reg = 3;
      gain_reg   = 1;
      pos = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return owed_q.size();
    endfunction

    function void write_reg(bbum_pkg::reg_index_t idx, logic [bbum_pkg::CFG_W-1:0] val);
      case (idx)
        bbum_pkg::REG_FRAME_WIDTH:  width_reg  = val;
        bbum_pkg::REG_FRAME_HEIGHT: height_reg = val;
        bbum_pkg::REG_WINDOW_SIZE:  window_reg = val[bbum_pkg::WIN_W-1:0];
        bbum_pkg::REG_GAIN:         gain_reg   = val[bbum_pkg::GAIN_W-1:0];
      endcase
      pos = 0;
    endfunction

    function int unsigned eff_w();
      return (width_reg < 2) ? 2 :
             (width_reg > bbum_pkg::MAX_WIDTH) ? bbum_pkg::MAX_WIDTH : width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg < 2) ? 2 :
             (height_reg > bbum_pkg::MAX_HEIGHT) ? bbum_pkg::MAX_HEIGHT : height_reg;
    endfunction

    function int unsigned eff_win();
      int unsigned v;
      v = window_reg | 1;
      return (v > bbum_pkg::MAX_WINDOW) ? bbum_pkg::MAX_WINDOW : v;
    endfunction

    function int clip(int v, int top);
      return (v < 0) ? 0 : (v > top) ? top : v;
    endfunction

    function void make_row_mean(int r, int c, int w, int size);
      int half, acc, d;
      half = (size - 1) / 2;
      acc = 0;
      for (d = 0; d < size; d++)
        acc += src_pix[r * w + clip(c + d - half, w - 1)];
      row_mean[r * w + c] = 8'(acc / size);
    endfunction

    function int col_blur(int r, int c, int w, int h, int size);
      int half, acc, d;
      half = (size - 1) / 2;
      acc = 0;
      for (d = 0; d < size; d++)
        acc += row_mean[clip(r + d - half, h - 1) * w + c];
      return acc / size;
    endfunction

    function void note_input(bbum_pkg::in_word_t iw);
      int w, h, size, half, total, lag, n, r, j, c, o, p, b, res;
      bbum_pkg::out_word_t ow;
      w = eff_w();
      h = eff_h();
      size = eff_win();
      half = (size - 1) / 2;
      total = w * h;
      lag = half * w + half;
      n = pos;
      if (n < total) begin
        // drain while filling is dropped
        if (iw.kind == bbum_pkg::KIND_DRAIN) return;
        src_pix[n] = iw.pixel;
        r = n / w;
        j = n % w;
        if (j == w - 1) begin
          for (c = (j >= half) ? j - half : 0; c < w; c++) make_row_mean(r, c, w, size);
        end else if (j >= half) begin
          make_row_mean(r, j - half, w, size);
        end
      end
      pos = n + 1;
      if (n < lag) return;
      o = n - lag;
      if (o >= total) begin
        pos = 0;
        return;
      end
      p = src_pix[o];
      b = col_blur(o / w, o % w, w, h, size);
      res = p + int'(gain_reg) * (p - b);
      if (res < 0) res = 0;
      if (res > 255) res = 255;
      ow.sharpened_pixel = 8'(res);
      ow.last_of_frame = (o == total - 1);
      if (ow.last_of_frame) pos = 0;
      owed_q.push_back(ow);
    endfunction

    task check_result(bbum_pkg::out_word_t got);
      bbum_pkg::out_word_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected word pix=%0d last=%0b",
                         got.sharpened_pixel, got.last_of_frame));
        return;
      end
      want = owed_q.pop_front();
      if (got.sharpened_pixel !== want.sharpened_pixel)
        report($sformatf("sharpened_pixel got %0d want %0d",
                         got.sharpened_pixel, want.sharpened_pixel));
      if (got.last_of_frame !== want.last_of_frame)
        report($sformatf("last_of_frame got %0b want %0b",
                         got.last_of_frame, want.last_of_frame));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [bbum_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  bbum_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  bbum_pkg::out_word_t out_data;

  bbum_scoreboard sb;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  box_blur_unsharp_mask_core i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // idle mix: receiver-heavy gaps, then sender-heavy, then none
  always_comb begin
    if (items_sent < ITEM_GOAL / 3) begin
      send_idle_pct = 21;
      recv_idle_pct = 50;
    end else if (items_sent < 2 * ITEM_GOAL / 3) begin
      send_idle_pct = 50;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("box_blur_unsharp_mask_core regression: fail");
        $finish;
      end
    end
  end

  // back end can still be building row means after the last owed word
  function int settle_cycles();
    int size, half;
    size = sb.eff_win();
    half = (size - 1) / 2;
    return (half + 2) * (2 * size + 20) + 4 * size + 100;
  endfunction

  task automatic send_item(logic kind, logic [7:0] pix);
    bbum_pkg::in_word_t iw;
    int gap;
    iw.kind = kind;
    iw.pixel = pix;
    in_valid <= 1'b1;
    in_data <= iw;
    do @(posedge clk); while (!in_ready);
    sb.note_input(iw);
    items_sent++;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (settle_cycles()) @(posedge clk);
  endtask

  // upper data bits beyond a register's width are noise and must be ignored
  task automatic set_regs(int w, int h, int win, int g);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= bbum_pkg::REG_FRAME_WIDTH;
    cfg_data <= bbum_pkg::CFG_W'(w);
    @(posedge clk);
    sb.write_reg(bbum_pkg::REG_FRAME_WIDTH, bbum_pkg::CFG_W'(w));
    cfg_index <= bbum_pkg::REG_FRAME_HEIGHT;
    cfg_data <= bbum_pkg::CFG_W'(h);
    @(posedge clk);
    sb.write_reg(bbum_pkg::REG_FRAME_HEIGHT, bbum_pkg::CFG_W'(h));
    cfg_index <= bbum_pkg::REG_WINDOW_SIZE;
    cfg_data <= {3'($urandom), 7'(win)};
    @(posedge clk);
    sb.write_reg(bbum_pkg::REG_WINDOW_SIZE, bbum_pkg::CFG_W'(win));
    cfg_index <= bbum_pkg::REG_GAIN;
    cfg_data <= {6'($urandom), 4'(g)};
    @(posedge clk);
    sb.write_reg(bbum_pkg::REG_GAIN, bbum_pkg::CFG_W'(g));
    cfg_wr_en <= 1'b0;
  endtask

  // extremes: every third pixel 255, the rest 0, so the clamp hits both rails
  task automatic run_frame(bit extremes);
    int total, lag, half, k;
    half = (sb.eff_win() - 1) / 2;
    total = sb.eff_w() * sb.eff_h();
    lag = half * sb.eff_w() + half;
    for (k = 0; k < total; k++) begin
      if ($urandom_range(0, 24) == 0) send_item(bbum_pkg::KIND_DRAIN, 8'($urandom));
      if (extremes) send_item(bbum_pkg::KIND_PIXEL, (k % 3 == 1) ? 8'd255 : 8'd0);
      else send_item(bbum_pkg::KIND_PIXEL, 8'($urandom));
    end
    // tail flush; a pixel word past the frame acts as a drain
    for (k = 0; k < lag; k++)
      send_item(($urandom_range(0, 3) == 0) ? bbum_pkg::KIND_PIXEL : bbum_pkg::KIND_DRAIN,
                8'($urandom));
  endtask

  initial begin
    int w, h, win;
    sb = new();
    items_sent = 0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= bbum_pkg::REG_FRAME_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_regs(2, 2, 1, 0);
    run_frame(1'b1);
    set_regs(3, 2, 3, 15);
    run_frame(1'b1);
    set_regs(0, 1, 2, 1);
    run_frame(1'b0);
    // config write mid-frame restarts it
    set_regs(1023, 1023, 127, 10);
    repeat (10) send_item(bbum_pkg::KIND_PIXEL, 8'($urandom));
    set_regs(3, 2, 127, 5);
    run_frame(1'b0);
    // widest rows, partial frame; results of the first row come out
    set_regs(1023, 0, 3, 15);
    repeat (600) send_item(bbum_pkg::KIND_PIXEL, 8'($urandom));

    while (items_sent < ITEM_GOAL) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(2, 10);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      win = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 31) : $urandom_range(0, 7);
      set_regs(w, h, win, $urandom_range(0, 15));
      repeat ($urandom_range(1, 2)) run_frame(1'b0);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("box_blur_unsharp_mask_core regression: pass");
    end else begin
      $display("box_blur_unsharp_mask_core regression: fail");
    end
    $finish;
  end

endmodule
